/* src/rfd_pkg.sv */
// Shared types, constants and codes for the remote-control frame decoder.
`timescale 1ns / 1ps

package rfd_pkg;

  localparam int FRAME_BYTES_DEF = 18;
  localparam int HOLD_LIMIT_DEF  = 100;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CH_W       = 11;
  localparam int NUM_CH     = 5;
  localparam int NUM_STICKS = 4;
  localparam int MOUSE_W    = 16;
  localparam int NUM_KEYS   = 16;
  localparam int NUM_TRK    = 18;
  localparam int CNT_W      = 7;
  localparam int DEC_BYTES  = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [10:0] CENTER_RST      = 11'd1024;
  localparam logic [9:0]  CH_LIMIT_RST    = 10'd660;
  localparam logic [14:0] MOUSE_LIMIT_RST = 15'd1000;
  localparam logic [1:0]  PC_LEFT_RST     = 2'd3;
  localparam logic [1:0]  PC_RIGHT_RST    = 2'd2;

  localparam logic signed [11:0] WHEEL_MAX = 12'sd1023;
  localparam logic signed [11:0] WHEEL_MIN = -12'sd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_CENTER  = 3'd0,
    CFG_CHANNEL_LIMIT   = 3'd1,
    CFG_MOUSE_LIMIT     = 3'd2,
    CFG_PC_SWITCH_LEFT  = 3'd3,
    CFG_PC_SWITCH_RIGHT = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    TRK_RELEASED = 2'd0,
    TRK_RISING   = 2'd1,
    TRK_HELD     = 2'd2,
    TRK_FALLING  = 2'd3
  } trk_state_t;

  typedef struct packed {
    logic [10:0] ch_center;
    logic [9:0]  ch_limit;
    logic [14:0] mouse_limit;
    logic [1:0]  pc_left;
    logic [1:0]  pc_right;
  } cfg_t;

  typedef struct packed {
    logic                         pc_mode;
    logic [NUM_CH-1:0][CH_W-1:0]  raw_ch;
    logic [1:0]                   sw_left;
    logic [1:0]                   sw_right;
    logic [MOUSE_W-1:0]           mouse_x;
    logic [MOUSE_W-1:0]           mouse_y;
    logic [NUM_KEYS-1:0]          keys;
    logic                         click_l;
    logic                         click_r;
  } frame_t;

  typedef struct packed {
    logic                             pc_mode;
    logic [NUM_STICKS-1:0][CH_W-1:0]  stick;
    logic [CH_W-1:0]                  wheel;
    logic [1:0]                       sw_left;
    logic [1:0]                       sw_right;
    logic [MOUSE_W-1:0]               mouse_dx;
    logic [MOUSE_W-1:0]               mouse_dy;
    logic [2*NUM_KEYS-1:0]            key_states;
    logic [3:0]                       click_states;
  } result_t;

endpackage

/* src/rc_frame_decoder_with_key_debounce_unit.sv */
// Top level of the remote-control frame decoder with key press tracking.
// A frame's last byte completes its entry in the frame queue; the back end then decodes it
// into the result queue, waiting while that queue is full, and the result ports show its head.
// Throughput: one byte per cycle while full is low; one frame decode per cycle in the back
// end, bounded by the two-entry frame queue and the two-entry result queue.
// Reset: synchronous, active high; clears byte position, held stick/wheel/mouse values,
// key trackers and both queues, and loads the register defaults.
`timescale 1ns / 1ps

module rc_frame_decoder_with_key_debounce_unit #(
  parameter int FRAME_BYTES = rfd_pkg::FRAME_BYTES_DEF,
  parameter int HOLD_LIMIT  = rfd_pkg::HOLD_LIMIT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Byte input, queue style.
  input  logic                               push,
  output logic                               full,
  input  logic [7:0]                         rx_byte,
  input  logic                               frame_start,
  // Result output, queue style.
  output logic                               empty,
  input  logic                               pop,
  output logic                               pc_mode,
  output logic signed [rfd_pkg::CH_W-1:0]    stick_0,
  output logic signed [rfd_pkg::CH_W-1:0]    stick_1,
  output logic signed [rfd_pkg::CH_W-1:0]    stick_2,
  output logic signed [rfd_pkg::CH_W-1:0]    stick_3,
  output logic signed [rfd_pkg::CH_W-1:0]    wheel_offset,
  output logic [1:0]                         left_switch,
  output logic [1:0]                         right_switch,
  output logic signed [rfd_pkg::MOUSE_W-1:0] mouse_dx,
  output logic signed [rfd_pkg::MOUSE_W-1:0] mouse_dy,
  output logic [31:0]                        key_states,
  output logic [3:0]                         click_states,
  // Register write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import rfd_pkg::*;

  cfg_t    cfg;
  logic    fq_push;
  frame_t  fq_in;
  logic    fq_full;
  logic    fq_pop;
  frame_t  fq_head;
  logic    fq_empty;
  logic    rq_push;
  result_t rq_in;
  logic    rq_full;
  result_t rq_head;

  // Register writes are always accepted; indexes past the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ch_center   <= CENTER_RST;
      cfg.ch_limit    <= CH_LIMIT_RST;
      cfg.mouse_limit <= MOUSE_LIMIT_RST;
      cfg.pc_left     <= PC_LEFT_RST;
      cfg.pc_right    <= PC_RIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHANNEL_CENTER:  cfg.ch_center   <= cfg_data[10:0];
        CFG_CHANNEL_LIMIT:   cfg.ch_limit    <= cfg_data[9:0];
        CFG_MOUSE_LIMIT:     cfg.mouse_limit <= cfg_data[14:0];
        CFG_PC_SWITCH_LEFT:  cfg.pc_left     <= cfg_data[1:0];
        CFG_PC_SWITCH_RIGHT: cfg.pc_right    <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: store bytes, classify the frame mode, transfer complete frames.
  rfd_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .cfg         (cfg),
    .q_full      (fq_full),
    .q_push      (fq_push),
    .q_data      (fq_in)
  );

  // Decouple front and back so each can stall on its own.
  rfd_fifo #(
    .WIDTH($bits(frame_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_frame_q (
    .clk       (clk),
    .rst       (rst),
    .push      (fq_push),
    .push_data (fq_in),
    .full      (fq_full),
    .pop       (fq_pop),
    .head      (fq_head),
    .empty     (fq_empty)
  );

  // Back end: decode and update held values and trackers.
  rfd_back #(
    .HOLD_LIMIT(HOLD_LIMIT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_empty (fq_empty),
    .in_frame (fq_head),
    .in_pop   (fq_pop),
    .out_full (rq_full),
    .out_push (rq_push),
    .out_data (rq_in)
  );

  // Result queue: hold finished results while the consumer stalls.
  rfd_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_result_q (
    .clk       (clk),
    .rst       (rst),
    .push      (rq_push),
    .push_data (rq_in),
    .full      (rq_full),
    .pop       (pop),
    .head      (rq_head),
    .empty     (empty)
  );

  assign pc_mode      = rq_head.pc_mode;
  assign stick_0      = rq_head.stick[0];
  assign stick_1      = rq_head.stick[1];
  assign stick_2      = rq_head.stick[2];
  assign stick_3      = rq_head.stick[3];
  assign wheel_offset = rq_head.wheel;
  assign left_switch  = rq_head.sw_left;
  assign right_switch = rq_head.sw_right;
  assign mouse_dx     = rq_head.mouse_dx;
  assign mouse_dy     = rq_head.mouse_dy;
  assign key_states   = rq_head.key_states;
  assign click_states = rq_head.click_states;

endmodule

/* src/rfd_fifo.sv */
// Small register queue used between the decoder stages and at the result side.
`timescale 1ns / 1ps

module rfd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rfd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |=> (rd_ptr == $past(rd_ptr))) else $error("read pointer moved while empty");
`endif

endmodule

/* src/rfd_front.sv */
// Front end: collects frame bytes and hands complete frames to the decode queue.
`timescale 1ns / 1ps

module rfd_front #(
  parameter int FRAME_BYTES = rfd_pkg::FRAME_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      rx_byte,
  input  logic            frame_start,
  input  rfd_pkg::cfg_t   cfg,
  input  logic            q_full,
  output logic            q_push,
  output rfd_pkg::frame_t q_data
);

  import rfd_pkg::*;

  localparam int IDX_W = $clog2(FRAME_BYTES);

  logic [7:0]       fb [FRAME_BYTES];
  logic [IDX_W-1:0] byte_index;
  logic [IDX_W-1:0] idx_eff;
  logic             accept;
  logic             last;
  logic [7:0]       b [DEC_BYTES];

  assign full    = q_full;
  assign accept  = push && !q_full;
  // A start mark restarts the frame and drops any partial one.
  assign idx_eff = frame_start ? '0 : byte_index;
  assign last    = (idx_eff == IDX_W'(FRAME_BYTES - 1));
  assign q_push  = accept && last;

  always_ff @(posedge clk) begin
    if (accept) begin
      fb[idx_eff] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
    end else if (accept) begin
      byte_index <= last ? '0 : idx_eff + 1'b1;
    end
  end

  // Frame view with the byte being transferred now merged in.
  always_comb begin
    for (int j = 0; j < DEC_BYTES; j++) begin
      b[j] = (idx_eff == IDX_W'(j)) ? rx_byte : fb[j];
    end
  end

  always_comb begin
    q_data.sw_left   = b[5][7:6];
    q_data.sw_right  = b[5][5:4];
    q_data.pc_mode   = (b[5][7:6] == cfg.pc_left) && (b[5][5:4] == cfg.pc_right);
    q_data.raw_ch[0] = {b[1][2:0], b[0]};
    q_data.raw_ch[1] = {b[2][5:0], b[1][7:3]};
    q_data.raw_ch[2] = {b[4][0], b[3], b[2][7:6]};
    q_data.raw_ch[3] = {b[5][3:0], b[4][7:1]};
    q_data.raw_ch[4] = {b[17][2:0], b[16]};
    q_data.mouse_x   = {b[7], b[6]};
    q_data.mouse_y   = {b[9], b[8]};
    q_data.keys      = {b[15], b[14]};
    q_data.click_l   = b[12][0];
    q_data.click_r   = b[13][0];
  end

endmodule

/* src/rfd_back.sv */
// Back end: one frame/cycle unless stalled; updates held values, key trackers.
`timescale 1ns / 1ps

module rfd_back #(
  parameter int HOLD_LIMIT = rfd_pkg::HOLD_LIMIT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  rfd_pkg::cfg_t    cfg,
  input  logic             in_empty,
  input  rfd_pkg::frame_t  in_frame,
  output logic             in_pop,
  input  logic             out_full,
  output logic             out_push,
  output rfd_pkg::result_t out_data
);

  import rfd_pkg::*;

  localparam logic [CNT_W-1:0] HOLD_MAX = CNT_W'(HOLD_LIMIT);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic                            proc;
  logic signed [CH_W:0]            diff [NUM_CH];
  logic signed [CH_W:0]            ch_lim;
  logic                            stick_bad;
  logic signed [MOUSE_W:0]         mx;
  logic signed [MOUSE_W:0]         my;
  logic signed [MOUSE_W:0]         m_lim;
  logic                            mouse_bad;
  logic [NUM_TRK-1:0]              pressed;

  logic [NUM_STICKS-1:0][CH_W-1:0] stick;
  logic [NUM_STICKS-1:0][CH_W-1:0] stick_next;
  logic [CH_W-1:0]                 wheel;
  logic [CH_W-1:0]                 wheel_next;
  logic [MOUSE_W-1:0]              mouse_x;
  logic [MOUSE_W-1:0]              mouse_x_next;
  logic [MOUSE_W-1:0]              mouse_y;
  logic [MOUSE_W-1:0]              mouse_y_next;
  logic [CNT_W-1:0]                cnt [NUM_TRK];
  logic [CNT_W-1:0]                cnt_next [NUM_TRK];
  trk_state_t                      st [NUM_TRK];
  trk_state_t                      st_next [NUM_TRK];

  assign proc     = !in_empty && !out_full;
  assign in_pop   = proc;
  assign out_push = proc;

  // Stick channels: offset from center, limit check on the four sticks.
  always_comb begin
    ch_lim    = $signed({2'b00, cfg.ch_limit});
    stick_bad = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      diff[i] = $signed({1'b0, in_frame.raw_ch[i]}) - $signed({1'b0, cfg.ch_center});
    end
    for (int i = 0; i < NUM_STICKS; i++) begin
      if ((diff[i] > ch_lim) || (diff[i] < -ch_lim)) begin
        stick_bad = 1'b1;
      end
    end
  end

  // Mouse: both axes drop to zero if either is out of range.
  always_comb begin
    mx        = $signed({in_frame.mouse_x[MOUSE_W-1], in_frame.mouse_x});
    my        = $signed({in_frame.mouse_y[MOUSE_W-1], in_frame.mouse_y});
    m_lim     = $signed({2'b00, cfg.mouse_limit});
    mouse_bad = (mx > m_lim) || (mx < -m_lim) || (my > m_lim) || (my < -m_lim);
  end

  always_comb begin
    stick_next   = stick;
    wheel_next   = wheel;
    mouse_x_next = mouse_x;
    mouse_y_next = mouse_y;
    pressed      = {in_frame.click_r, in_frame.click_l, in_frame.keys};
    for (int k = 0; k < NUM_TRK; k++) begin
      cnt_next[k] = cnt[k];
      st_next[k]  = st[k];
    end
    if (!in_frame.pc_mode) begin
      for (int i = 0; i < NUM_STICKS; i++) begin
        stick_next[i] = stick_bad ? '0 : diff[i][CH_W-1:0];
      end
      if (diff[NUM_CH-1] > WHEEL_MAX) begin
        wheel_next = WHEEL_MAX[CH_W-1:0];
      end else if (diff[NUM_CH-1] < WHEEL_MIN) begin
        wheel_next = WHEEL_MIN[CH_W-1:0];
      end else begin
        wheel_next = diff[NUM_CH-1][CH_W-1:0];
      end
    end else begin
      mouse_x_next = mouse_bad ? '0 : in_frame.mouse_x;
      mouse_y_next = mouse_bad ? '0 : in_frame.mouse_y;
      for (int k = 0; k < NUM_TRK; k++) begin
        if (!pressed[k]) begin
          cnt_next[k] = '0;
        end else if (cnt[k] >= HOLD_MAX) begin
          cnt_next[k] = HOLD_MAX;
        end else begin
          cnt_next[k] = cnt[k] + 1'b1;
        end
        if (cnt_next[k] > CNT_ONE) begin
          st_next[k] = TRK_HELD;
        end else if (cnt_next[k] == CNT_ONE) begin
          st_next[k] = TRK_RISING;
        end else begin
          st_next[k] = (st[k] == TRK_HELD) ? TRK_FALLING : TRK_RELEASED;
        end
      end
    end
  end

  always_comb begin
    out_data.pc_mode  = in_frame.pc_mode;
    out_data.stick    = stick_next;
    out_data.wheel    = wheel_next;
    out_data.sw_left  = in_frame.sw_left;
    out_data.sw_right = in_frame.sw_right;
    out_data.mouse_dx = mouse_x_next;
    out_data.mouse_dy = mouse_y_next;
    for (int i = 0; i < NUM_KEYS; i++) begin
      out_data.key_states[2*i +: 2] = st_next[i];
    end
    out_data.click_states = {st_next[NUM_KEYS + 1], st_next[NUM_KEYS]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stick   <= '0;
      wheel   <= '0;
      mouse_x <= '0;
      mouse_y <= '0;
      for (int k = 0; k < NUM_TRK; k++) begin
        cnt[k] <= '0;
        st[k]  <= TRK_RELEASED;
      end
    end else if (proc) begin
      stick   <= stick_next;
      wheel   <= wheel_next;
      mouse_x <= mouse_x_next;
      mouse_y <= mouse_y_next;
      for (int k = 0; k < NUM_TRK; k++) begin
        cnt[k] <= cnt_next[k];
        st[k]  <= st_next[k];
      end
    end
  end

`ifndef SYNTH
  a_stick_zeroed: assert property (@(posedge clk) disable iff (rst)
    proc && !in_frame.pc_mode && stick_bad |=> (stick == '0))
    else $error("sticks not zeroed after out-of-range channel");
  a_stick_held: assert property (@(posedge clk) disable iff (rst)
    proc && in_frame.pc_mode |=> (stick == $past(stick)) && (wheel == $past(wheel)))
    else $error("pc frame changed stick values");
  a_mouse_zeroed: assert property (@(posedge clk) disable iff (rst)
    proc && in_frame.pc_mode && mouse_bad |=> (mouse_x == '0) && (mouse_y == '0))
    else $error("mouse not zeroed after out-of-range speed");
  a_trk_consistent: assert property (@(posedge clk) disable iff (rst)
    (cnt[0] <= HOLD_MAX) && ((st[0] == TRK_RISING) == (cnt[0] == CNT_ONE)))
    else $error("key tracker count and state disagree");
`endif

endmodule
